// ===== rtl/sndcp_pkg.sv =====
// Shared types and constants for the serial/network/drive control port block.
// Used by the drive cells, the comms unit and the top level.
`default_nettype none

package sndcp_pkg;

    localparam int CNT_W   = 4;
    localparam int PHASE_W = 10;

    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [PHASE_W-1:0] t_phase;

    // Port select from address bits 4:3
    typedef enum logic [1:0] {
        PORT_DRIVE = 2'd0,
        PORT_CTRL  = 2'd1,
        PORT_LAN   = 2'd2,
        PORT_NONE  = 2'd3
    } t_port_sel;

    typedef enum logic [1:0] {
        CFG_IFACE_EN = 2'd0,
        CFG_PRESENT  = 2'd1,
        CFG_WPROT    = 2'd2,
        CFG_SER_CONN = 2'd3
    } t_cfg_idx;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic SEND_SERIAL  = 1'b0;
    localparam logic SEND_STATION = 1'b1;

    localparam logic [7:0] IDLE_VALUE = 8'hFF;

    // Serial receive (toward CPU) and transmit bit counters
    localparam t_cnt RX_LEAD_END = 4'd5;
    localparam t_cnt RX_DATA_END = 4'd13;
    localparam t_cnt TX_DATA_END = 4'd9;
    localparam t_cnt TX_STOP_END = 4'd10;

    // Network handshake phases
    localparam t_phase NET_WAIT_PHASE     = 10'h100;
    localparam t_phase NET_LAST_BIT_PHASE = 10'h10A;
    localparam t_phase NET_STATION_PHASE  = 10'h200;
    localparam t_phase NET_STATION_DONE   = 10'h208;
    localparam t_phase NET_IDLE_LIMIT     = 10'd192;

    // Status flags rippling along the drive cells
    typedef struct packed {
        logic gap_zero;
        logic wprot;
    } t_cell_link;

    // One decoded bus request as seen by the comms unit
    typedef struct packed {
        logic       ctrl_wr;
        logic       net_rd;
        logic       net_wr;
        logic [7:0] value;
        logic       ser_ready;
        logic [7:0] ser_byte;
        logic       net_ready;
        logic [7:0] net_byte;
        logic       ser_conn;
    } t_comms_req;

    typedef struct packed {
        logic       motor_shift;
        logic       motor_in;
        logic [7:0] net_rd_val;
        logic       ser_taken;
        logic       net_taken;
        logic       send_valid;
        logic       send_target;
        logic [7:0] send_byte;
    } t_comms_res;

endpackage

`default_nettype wire

// ===== rtl/sndcp_drive_cell.sv =====
// One drive cell: motor chain bit plus gap and sync counters.
// Depends on sndcp_pkg; chained by the top level, flags ripple cell to cell.
`default_nettype none

module sndcp_drive_cell #(
    parameter int GAP_SYNC_RELOAD = 15
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_step,
    input  wire                     i_shift,
    input  wire                     i_motor_in,
    input  wire                     i_present,
    input  wire                     i_wprot,
    input  sndcp_pkg::t_cell_link   i_link,
    output logic                    o_motor,
    output sndcp_pkg::t_cell_link   o_link
);

    localparam sndcp_pkg::t_cnt RELOAD = sndcp_pkg::t_cnt'(GAP_SYNC_RELOAD);

    logic            r_motor, n_motor;
    sndcp_pkg::t_cnt r_gap, n_gap;
    sndcp_pkg::t_cnt r_sync, n_sync;
    logic            w_active;

    assign w_active = r_motor & i_present;

    always_comb begin
        n_motor = r_motor;
        n_gap   = r_gap;
        n_sync  = r_sync;
        if (i_shift) begin
            n_motor = i_motor_in;
        end
        if (i_step && w_active) begin
            if (r_gap != '0) begin
                n_gap = r_gap - sndcp_pkg::t_cnt'(1);
            end else if (r_sync != '0) begin
                n_sync = r_sync - sndcp_pkg::t_cnt'(1);
            end else begin
                n_gap  = RELOAD;
                n_sync = RELOAD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor <= 1'b0;
            r_gap   <= RELOAD;
            r_sync  <= RELOAD;
        end else begin
            r_motor <= n_motor;
            r_gap   <= n_gap;
            r_sync  <= n_sync;
        end
    end

    assign o_motor       = r_motor;
    // flags use the counts seen before this request's update
    assign o_link.gap_zero = i_link.gap_zero | (w_active & (r_gap == '0));
    assign o_link.wprot    = i_link.wprot | (w_active & i_wprot);

endmodule

`default_nettype wire

// ===== rtl/sndcp_comms.sv =====
// Control latch, serial line and network handshake logic.
// Depends on sndcp_pkg; driven by decoded requests from the top level.
`default_nettype none

module sndcp_comms (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  sndcp_pkg::t_comms_req   i_req,
    output sndcp_pkg::t_comms_res   o_res
);

    // control latch: comms data, clock, cts (the wait bit has no effect here)
    logic              r_data, n_data;
    logic              r_clk, n_clk;
    logic              r_cts, n_cts;
    // line bits: tx toward CPU, rx from CPU, network
    logic              r_line_tx, n_line_tx;
    logic              r_line_rx, n_line_rx;
    logic              r_line_net, n_line_net;
    sndcp_pkg::t_cnt   r_rx_count, n_rx_count;
    logic [7:0]        r_rx_shift, n_rx_shift;
    sndcp_pkg::t_cnt   r_tx_count, n_tx_count;
    logic [7:0]        r_tx_shift, n_tx_shift;
    sndcp_pkg::t_phase r_net_phase, n_net_phase;
    logic [7:0]        r_net_shift, n_net_shift;
    logic              w_b;

    assign w_b = i_req.value[0];

    always_comb begin
        n_data      = r_data;
        n_clk       = r_clk;
        n_cts       = r_cts;
        n_line_tx   = r_line_tx;
        n_line_rx   = r_line_rx;
        n_line_net  = r_line_net;
        n_rx_count  = r_rx_count;
        n_rx_shift  = r_rx_shift;
        n_tx_count  = r_tx_count;
        n_tx_shift  = r_tx_shift;
        n_net_phase = r_net_phase;
        n_net_shift = r_net_shift;
        o_res             = '0;
        o_res.motor_in    = ~i_req.value[0];
        o_res.net_rd_val  = sndcp_pkg::IDLE_VALUE;

        if (i_req.ctrl_wr) begin
            o_res.motor_shift = ~i_req.value[1] & r_clk;
            // rising comms data restarts both serial counters
            if (i_req.value[0] && !r_data) begin
                n_tx_count = '0;
                n_tx_shift = '0;
                n_rx_count = '0;
                n_rx_shift = '0;
            end
            n_data = i_req.value[0];
            n_clk  = i_req.value[1];
            n_cts  = i_req.value[4];
        end

        if (i_req.net_rd) begin
            if (r_cts) begin
                if (r_rx_count == '0) begin
                    if (i_req.ser_ready) begin
                        n_rx_shift      = i_req.ser_byte;
                        n_rx_count      = sndcp_pkg::t_cnt'(1);
                        o_res.ser_taken = 1'b1;
                    end
                    n_line_tx = 1'b0;
                end else if (r_rx_count < sndcp_pkg::RX_LEAD_END) begin
                    n_line_tx  = 1'b1;
                    n_rx_count = r_rx_count + sndcp_pkg::t_cnt'(1);
                end else if (r_rx_count < sndcp_pkg::RX_DATA_END) begin
                    // data goes out inverted, lsb first
                    n_line_tx  = ~r_rx_shift[0];
                    n_rx_shift = {1'b0, r_rx_shift[7:1]};
                    n_rx_count = r_rx_count + sndcp_pkg::t_cnt'(1);
                end else begin
                    n_rx_count = '0;
                end
            end else begin
                n_rx_count = '0;
                n_line_tx  = 1'b0;
            end

            if (r_net_phase < sndcp_pkg::NET_WAIT_PHASE) begin
                n_net_phase = r_net_phase + sndcp_pkg::t_phase'(1);
                n_line_net  = 1'b0;
            end else if (r_net_phase == sndcp_pkg::NET_WAIT_PHASE) begin
                if (i_req.net_ready) begin
                    n_net_shift     = i_req.net_byte;
                    n_net_phase     = r_net_phase + sndcp_pkg::t_phase'(1);
                    n_line_net      = 1'b1;
                    o_res.net_taken = 1'b1;
                end
            end else if (r_net_phase == sndcp_pkg::NET_WAIT_PHASE
                                       + sndcp_pkg::t_phase'(1)) begin
                n_net_phase = r_net_phase + sndcp_pkg::t_phase'(1);
                n_line_net  = 1'b1;
            end else if (r_net_phase < sndcp_pkg::NET_LAST_BIT_PHASE) begin
                n_net_phase = r_net_phase + sndcp_pkg::t_phase'(1);
                n_line_net  = r_net_shift[0];
                n_net_shift = {1'b0, r_net_shift[7:1]};
            end else if (r_net_phase == sndcp_pkg::NET_LAST_BIT_PHASE) begin
                n_line_net  = 1'b0;
                n_net_phase = '0;
            end

            o_res.net_rd_val = {n_line_tx, 6'b111111, n_line_net};
        end

        if (i_req.net_wr) begin
            if (r_data) begin
                if (r_tx_count == '0) begin
                    if (!r_line_rx && w_b) begin
                        n_tx_count = sndcp_pkg::t_cnt'(1);
                    end
                end else if (r_tx_count < sndcp_pkg::TX_DATA_END) begin
                    n_tx_shift = {~w_b, r_tx_shift[7:1]};
                    n_tx_count = r_tx_count + sndcp_pkg::t_cnt'(1);
                end else if (r_tx_count < sndcp_pkg::TX_STOP_END) begin
                    n_tx_count = r_tx_count + sndcp_pkg::t_cnt'(1);
                end else begin
                    if (i_req.ser_conn) begin
                        o_res.send_valid  = 1'b1;
                        o_res.send_target = sndcp_pkg::SEND_SERIAL;
                        o_res.send_byte   = r_tx_shift;
                    end
                    n_tx_count = '0;
                    n_tx_shift = '0;
                end
                n_line_rx = w_b;
            end else begin
                if (r_net_phase >= sndcp_pkg::NET_STATION_PHASE
                        && r_net_phase < sndcp_pkg::NET_STATION_DONE) begin
                    n_net_phase = r_net_phase + sndcp_pkg::t_phase'(1);
                    n_net_shift = {r_net_shift[6:0], ~w_b};
                end else if (r_net_phase == sndcp_pkg::NET_STATION_DONE) begin
                    // terminal phase: handshake stays idle from here on
                    n_net_phase       = r_net_phase + sndcp_pkg::t_phase'(1);
                    o_res.send_valid  = 1'b1;
                    o_res.send_target = sndcp_pkg::SEND_STATION;
                    o_res.send_byte   = r_net_shift;
                end else if (r_net_phase > sndcp_pkg::NET_IDLE_LIMIT
                        && r_net_phase < sndcp_pkg::NET_STATION_PHASE && !w_b) begin
                    n_net_phase = sndcp_pkg::NET_STATION_PHASE;
                end
                n_line_net = ~w_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data      <= 1'b0;
            r_clk       <= 1'b0;
            r_cts       <= 1'b0;
            r_line_tx   <= 1'b0;
            r_line_rx   <= 1'b0;
            r_line_net  <= 1'b0;
            r_rx_count  <= '0;
            r_rx_shift  <= '0;
            r_tx_count  <= '0;
            r_tx_shift  <= '0;
            r_net_phase <= '0;
            r_net_shift <= '0;
        end else begin
            r_data      <= n_data;
            r_clk       <= n_clk;
            r_cts       <= n_cts;
            r_line_tx   <= n_line_tx;
            r_line_rx   <= n_line_rx;
            r_line_net  <= n_line_net;
            r_rx_count  <= n_rx_count;
            r_rx_shift  <= n_rx_shift;
            r_tx_count  <= n_tx_count;
            r_tx_shift  <= n_tx_shift;
            r_net_phase <= n_net_phase;
            r_net_shift <= n_net_shift;
        end
    end

    a_rx_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rx_count <= sndcp_pkg::RX_DATA_END)
        else $error("rx counter out of range");

    a_tx_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_count <= sndcp_pkg::TX_STOP_END)
        else $error("tx counter out of range");

    a_net_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_net_phase <= sndcp_pkg::NET_STATION_DONE + sndcp_pkg::t_phase'(1))
        else $error("network phase past terminal value");

endmodule

`default_nettype wire

// ===== rtl/serial_net_drive_control_ports.sv =====
// Latency: a request's result is valid in the cycle after acceptance.
// Throughput: one request per cycle unless the output register holds a
// stalled result; each is done in the single update stage ahead of it.
// Reset (synchronous, active low) clears configuration and state, except
// result data; gap/sync counters load the reload value. No clearing pass.
`default_nettype none

module serial_net_drive_control_ports #(
    parameter int DRIVE_COUNT     = 8,
    parameter int GAP_SYNC_RELOAD = 15
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration write port
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_idx,
    input  wire  [7:0]  i_cfg_data,
    // request channel
    input  wire         i_valid,
    output logic        o_ready,
    input  wire         i_cmd,
    input  wire  [15:0] i_port_address,
    input  wire  [7:0]  i_write_value,
    input  wire         i_serial_byte_ready,
    input  wire  [7:0]  i_serial_byte,
    input  wire         i_net_byte_ready,
    input  wire  [7:0]  i_net_byte,
    // result channel
    output logic        o_valid,
    input  wire         i_ready,
    output logic [7:0]  o_read_value,
    output logic        o_claimed,
    output logic        o_serial_byte_taken,
    output logic        o_net_byte_taken,
    output logic        o_send_valid,
    output logic        o_send_target,
    output logic [7:0]  o_send_byte,
    output logic [7:0]  o_motors_on
);

    logic                   r_iface_en;
    logic [DRIVE_COUNT-1:0] r_present;
    logic [DRIVE_COUNT-1:0] r_wprot;
    logic                   r_ser_conn;

    logic                   w_acc;
    logic                   w_live;
    sndcp_pkg::t_port_sel   w_sel;
    logic                   w_ctrl_rd;
    sndcp_pkg::t_comms_req  w_req;
    sndcp_pkg::t_comms_res  w_res;
    logic [DRIVE_COUNT-1:0] w_motor;
    logic [DRIVE_COUNT-1:0] w_chain_in;
    sndcp_pkg::t_cell_link  w_link [DRIVE_COUNT+1];
    logic [7:0]             w_ctrl_val;
    logic [7:0]             w_read_val;

    logic                   r_out_valid;
    logic [7:0]             r_read_value;
    logic                   r_claimed;
    logic                   r_ser_taken;
    logic                   r_net_taken;
    logic                   r_send_valid;
    logic                   r_send_target;
    logic [7:0]             r_send_byte;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iface_en <= 1'b0;
            r_present  <= '0;
            r_wprot    <= '0;
            r_ser_conn <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (sndcp_pkg::t_cfg_idx'(i_cfg_idx))
                sndcp_pkg::CFG_IFACE_EN: r_iface_en <= i_cfg_data[0];
                sndcp_pkg::CFG_PRESENT:  r_present  <= i_cfg_data[DRIVE_COUNT-1:0];
                sndcp_pkg::CFG_WPROT:    r_wprot    <= i_cfg_data[DRIVE_COUNT-1:0];
                sndcp_pkg::CFG_SER_CONN: r_ser_conn <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // request decode
    assign o_ready   = !r_out_valid || i_ready;
    assign w_acc     = i_valid && o_ready;
    assign w_live    = w_acc && r_iface_en;
    assign w_sel     = sndcp_pkg::t_port_sel'(i_port_address[4:3]);
    assign w_ctrl_rd = w_live && (i_cmd == sndcp_pkg::CMD_READ)
                       && (w_sel == sndcp_pkg::PORT_CTRL);

    always_comb begin
        w_req           = '0;
        w_req.ctrl_wr   = w_live && (i_cmd == sndcp_pkg::CMD_WRITE)
                          && (w_sel == sndcp_pkg::PORT_CTRL);
        w_req.net_rd    = w_live && (i_cmd == sndcp_pkg::CMD_READ)
                          && (w_sel == sndcp_pkg::PORT_LAN);
        w_req.net_wr    = w_live && (i_cmd == sndcp_pkg::CMD_WRITE)
                          && (w_sel == sndcp_pkg::PORT_LAN);
        w_req.value     = i_write_value;
        w_req.ser_ready = i_serial_byte_ready;
        w_req.ser_byte  = i_serial_byte;
        w_req.net_ready = i_net_byte_ready;
        w_req.net_byte  = i_net_byte;
        w_req.ser_conn  = r_ser_conn;
    end

    sndcp_comms u_comms (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_res   (w_res)
    );

    // drive cell chain: motor bit moves up one cell per clock-falling write
    assign w_link[0] = '0;

    for (genvar g = 0; g < DRIVE_COUNT; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_chain_in[g] = w_res.motor_in;
        end else begin : g_body
            assign w_chain_in[g] = w_motor[g-1];
        end

        sndcp_drive_cell #(
            .GAP_SYNC_RELOAD (GAP_SYNC_RELOAD)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_step     (w_ctrl_rd),
            .i_shift    (w_res.motor_shift),
            .i_motor_in (w_chain_in[g]),
            .i_present  (r_present[g]),
            .i_wprot    (r_wprot[g]),
            .i_link     (w_link[g]),
            .o_motor    (w_motor[g]),
            .o_link     (w_link[g+1])
        );
    end

    // busy flag (active low) always set: bit 4 always low
    assign w_ctrl_val = {3'b111, 1'b0, r_ser_conn,
                         ~w_link[DRIVE_COUNT].gap_zero,
                         ~w_link[DRIVE_COUNT].gap_zero,
                         ~w_link[DRIVE_COUNT].wprot};

    always_comb begin
        w_read_val = sndcp_pkg::IDLE_VALUE;
        if (r_iface_en && (i_cmd == sndcp_pkg::CMD_READ)) begin
            unique case (w_sel)
                sndcp_pkg::PORT_CTRL:  w_read_val = w_ctrl_val;
                sndcp_pkg::PORT_LAN:   w_read_val = w_res.net_rd_val;
                sndcp_pkg::PORT_DRIVE,
                sndcp_pkg::PORT_NONE:  w_read_val = sndcp_pkg::IDLE_VALUE;
                default:               w_read_val = sndcp_pkg::IDLE_VALUE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_read_value  <= w_read_val;
            r_claimed     <= r_iface_en && (i_cmd == sndcp_pkg::CMD_READ);
            r_ser_taken   <= w_res.ser_taken;
            r_net_taken   <= w_res.net_taken;
            r_send_valid  <= w_res.send_valid;
            r_send_target <= w_res.send_target;
            r_send_byte   <= w_res.send_byte;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_read_value        = r_read_value;
    assign o_claimed           = r_claimed;
    assign o_serial_byte_taken = r_ser_taken;
    assign o_net_byte_taken    = r_net_taken;
    assign o_send_valid        = r_send_valid;
    assign o_send_target       = r_send_target;
    assign o_send_byte         = r_send_byte;
    // motor chain only moves on an accepted request, so it matches the held result
    assign o_motors_on         = 8'(w_motor);

    a_send_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_send_valid |-> !o_claimed && o_read_value == sndcp_pkg::IDLE_VALUE)
        else $error("byte sent on a read request");

    a_taken_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_serial_byte_taken || o_net_byte_taken) |-> o_claimed && !o_send_valid)
        else $error("host byte taken outside a claimed read");

    a_disabled_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && !r_iface_en |=> o_valid && !o_claimed && !o_send_valid
            && o_read_value == sndcp_pkg::IDLE_VALUE)
        else $error("request answered while interface disabled");

endmodule

`default_nettype wire

// ===== bench/port_access_checker.sv =====
// Checker for serial_net_drive_control_ports: snoops the register port and both
// channels, predicts each bus access result and compares it field by field.
// Depends on sndcp_pkg for port-select, register-index and send-target codes.
module port_access_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_idx,
    input  wire  [7:0]  i_cfg_data,
    input  wire         i_req_valid,
    input  wire         i_req_ready,
    input  wire         i_cmd,
    input  wire  [15:0] i_port_address,
    input  wire  [7:0]  i_write_value,
    input  wire         i_serial_byte_ready,
    input  wire  [7:0]  i_serial_byte,
    input  wire         i_net_byte_ready,
    input  wire  [7:0]  i_net_byte,
    input  wire         i_res_valid,
    input  wire         i_res_ready,
    input  wire  [7:0]  i_read_value,
    input  wire         i_claimed,
    input  wire         i_serial_byte_taken,
    input  wire         i_net_byte_taken,
    input  wire         i_send_valid,
    input  wire         i_send_target,
    input  wire  [7:0]  i_send_byte,
    input  wire  [7:0]  i_motors_on,
    output int          o_pending,
    output int          o_fail_count
);

    localparam int                DRIVES          = 8;
    localparam sndcp_pkg::t_cnt   GAP_RELOAD      = 4'd15;
    localparam sndcp_pkg::t_cnt   RX_HDR_LAST     = 4'd5;
    localparam sndcp_pkg::t_cnt   RX_BITS_LAST    = 4'd13;
    localparam sndcp_pkg::t_cnt   TX_BITS_LAST    = 4'd9;
    localparam sndcp_pkg::t_cnt   TX_STOP_LAST    = 4'd10;
    localparam sndcp_pkg::t_phase PH_WAIT         = 10'h100;
    localparam sndcp_pkg::t_phase PH_LAST_BIT     = 10'h10A;
    localparam sndcp_pkg::t_phase PH_STATION      = 10'h200;
    localparam sndcp_pkg::t_phase PH_STATION_DONE = 10'h208;
    localparam sndcp_pkg::t_phase PH_IDLE_MIN     = 10'd192;

    localparam logic [7:0] ST_WPROT    = 8'hFE;
    localparam logic [7:0] ST_GAP_SYNC = 8'hF9;
    localparam logic [7:0] ST_NO_DTR   = 8'hF7;
    localparam logic [7:0] ST_BUSY     = 8'hEF;
    localparam logic [7:0] NET_NO_RX   = 8'h7F;
    localparam logic [7:0] NET_NO_LINE = 8'hFE;

    typedef struct packed {
        logic [7:0] read_value;
        logic       claimed;
        logic       serial_byte_taken;
        logic       net_byte_taken;
        logic       send_valid;
        logic       send_target;
        logic [7:0] send_byte;
        logic [7:0] motors_on;
    } t_port_result;

    // configuration copy
    logic       iface_en;
    logic [7:0] present_mask;
    logic [7:0] wprot_mask;
    logic       dtr_connected;

    // block state copy
    logic [7:0]         motors;
    sndcp_pkg::t_cnt    gap_left [DRIVES];
    sndcp_pkg::t_cnt    sync_left [DRIVES];
    logic               data_bit, clk_bit, cts;
    logic               line_to_cpu, line_from_cpu, net_line;
    sndcp_pkg::t_cnt    rx_cnt, tx_cnt;
    logic [7:0]         rx_sr, tx_sr, net_sr;
    sndcp_pkg::t_phase  phase;

    t_port_result awaited_results [$];
    int mismatches = 0;

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
    end

    function automatic logic [7:0] status_read();
        logic [7:0] r;
        r = 8'hFF;
        for (int d = 0; d < DRIVES; d++) begin
            if (motors[d] && present_mask[d]) begin
                if (gap_left[d] != 0) begin
                    gap_left[d] = gap_left[d] - 1'b1;
                end else begin
                    r &= ST_GAP_SYNC;
                    if (sync_left[d] != 0) begin
                        sync_left[d] = sync_left[d] - 1'b1;
                    end else begin
                        gap_left[d]  = GAP_RELOAD;
                        sync_left[d] = GAP_RELOAD;
                    end
                end
                if (wprot_mask[d]) r &= ST_WPROT;
            end
        end
        if (!dtr_connected) r &= ST_NO_DTR;
        return r & ST_BUSY;
    endfunction

    function automatic void control_write(input logic [7:0] v);
        // falling clock bit shifts the motor chain; a low data bit starts a motor
        if (!v[1] && clk_bit) motors = {motors[6:0], ~v[0]};
        if (v[0] && !data_bit) begin
            tx_cnt = '0;
            tx_sr  = '0;
            rx_cnt = '0;
            rx_sr  = '0;
        end
        data_bit = v[0];
        clk_bit  = v[1];
        cts      = v[4];
    endfunction

    function automatic void network_read(input logic ser_rdy, input logic [7:0] ser_b,
                                         input logic net_rdy, input logic [7:0] net_b,
                                         inout t_port_result res);
        logic [7:0] r;
        r = 8'hFF;
        if (cts) begin
            if (rx_cnt == 0) begin
                if (ser_rdy) begin
                    rx_sr = ser_b;
                    rx_cnt = 4'd1;
                    res.serial_byte_taken = 1'b1;
                end
                line_to_cpu = 1'b0;
            end else if (rx_cnt < RX_HDR_LAST) begin
                line_to_cpu = 1'b1;
                rx_cnt++;
            end else if (rx_cnt < RX_BITS_LAST) begin
                line_to_cpu = ~rx_sr[0];
                rx_sr >>= 1;
                rx_cnt++;
            end else begin
                rx_cnt = '0;
            end
        end else begin
            rx_cnt = '0;
            line_to_cpu = 1'b0;
        end

        if (phase < PH_WAIT) begin
            phase++;
            net_line = 1'b0;
        end else if (phase == PH_WAIT) begin
            if (net_rdy) begin
                net_sr = net_b;
                phase++;
                net_line = 1'b1;
                res.net_byte_taken = 1'b1;
            end
        end else if (phase == PH_WAIT + 1) begin
            phase++;
            net_line = 1'b1;
        end else if (phase < PH_LAST_BIT) begin
            phase++;
            net_line = net_sr[0];
            net_sr >>= 1;
        end else if (phase == PH_LAST_BIT) begin
            net_line = 1'b0;
            phase = '0;
        end

        if (!line_to_cpu) r &= NET_NO_RX;
        if (!net_line) r &= NET_NO_LINE;
        res.read_value = r;
    endfunction

    function automatic void network_write(input logic b, inout t_port_result res);
        if (data_bit) begin
            if (tx_cnt == 0) begin
                if (!line_from_cpu && b) tx_cnt = 4'd1;
            end else if (tx_cnt < TX_BITS_LAST) begin
                tx_sr = {~b, tx_sr[7:1]};
                tx_cnt++;
            end else if (tx_cnt < TX_STOP_LAST) begin
                tx_cnt++;
            end else begin
                if (dtr_connected) begin
                    res.send_valid  = 1'b1;
                    res.send_target = sndcp_pkg::SEND_SERIAL;
                    res.send_byte   = tx_sr;
                end
                tx_cnt = '0;
                tx_sr  = '0;
            end
            line_from_cpu = b;
        end else begin
            if (phase >= PH_STATION && phase < PH_STATION_DONE) begin
                phase++;
                net_sr = {net_sr[6:0], ~b};
            end else if (phase == PH_STATION_DONE) begin
                // park the handshake once the station number is out
                phase++;
                res.send_valid  = 1'b1;
                res.send_target = sndcp_pkg::SEND_STATION;
                res.send_byte   = net_sr;
            end else if (phase > PH_IDLE_MIN && phase < PH_STATION && !b) begin
                phase = PH_STATION;
            end
            net_line = ~b;
        end
    endfunction

    function automatic t_port_result predict_access(
        input logic cmd, input logic [15:0] addr, input logic [7:0] wval,
        input logic ser_rdy, input logic [7:0] ser_b,
        input logic net_rdy, input logic [7:0] net_b);
        t_port_result         res;
        sndcp_pkg::t_port_sel sel;
        res = '0;
        res.read_value = 8'hFF;
        sel = sndcp_pkg::t_port_sel'(addr[4:3]);
        if (iface_en) begin
            if (cmd == sndcp_pkg::CMD_READ) begin
                res.claimed = 1'b1;
                if (sel == sndcp_pkg::PORT_CTRL) begin
                    res.read_value = status_read();
                end else if (sel == sndcp_pkg::PORT_LAN) begin
                    network_read(ser_rdy, ser_b, net_rdy, net_b, res);
                end
            end else begin
                if (sel == sndcp_pkg::PORT_CTRL) control_write(wval);
                else if (sel == sndcp_pkg::PORT_LAN) network_write(wval[0], res);
            end
        end
        res.motors_on = motors;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_port_result got, want;
        if (!i_rst_n) begin
            iface_en      = 1'b0;
            present_mask  = '0;
            wprot_mask    = '0;
            dtr_connected = 1'b0;
            motors        = '0;
            for (int d = 0; d < DRIVES; d++) begin
                gap_left[d]  = GAP_RELOAD;
                sync_left[d] = GAP_RELOAD;
            end
            {data_bit, clk_bit, cts} = '0;
            {line_to_cpu, line_from_cpu, net_line} = '0;
            rx_cnt = '0;
            tx_cnt = '0;
            rx_sr  = '0;
            tx_sr  = '0;
            net_sr = '0;
            phase  = '0;
            awaited_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (sndcp_pkg::t_cfg_idx'(i_cfg_idx))
                    sndcp_pkg::CFG_IFACE_EN: iface_en      = i_cfg_data[0];
                    sndcp_pkg::CFG_PRESENT:  present_mask  = i_cfg_data;
                    sndcp_pkg::CFG_WPROT:    wprot_mask    = i_cfg_data;
                    sndcp_pkg::CFG_SER_CONN: dtr_connected = i_cfg_data[0];
                    default: ;
                endcase
            end
            // retire the oldest result before queueing this edge's request
            if (i_res_valid && i_res_ready) begin
                got = {i_read_value, i_claimed, i_serial_byte_taken, i_net_byte_taken,
                       i_send_valid, i_send_target, i_send_byte, i_motors_on};
                if (awaited_results.size() == 0) begin
                    $error("result with no request outstanding");
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("read_value", want.read_value, got.read_value);
                    check_field("claimed", want.claimed, got.claimed);
                    check_field("serial_byte_taken", want.serial_byte_taken,
                                got.serial_byte_taken);
                    check_field("net_byte_taken", want.net_byte_taken, got.net_byte_taken);
                    check_field("send_valid", want.send_valid, got.send_valid);
                    check_field("send_target", want.send_target, got.send_target);
                    check_field("send_byte", want.send_byte, got.send_byte);
                    check_field("motors_on", want.motors_on, got.motors_on);
                end
            end
            if (i_req_valid && i_req_ready) begin
                awaited_results.push_back(predict_access(i_cmd, i_port_address,
                    i_write_value, i_serial_byte_ready, i_serial_byte,
                    i_net_byte_ready, i_net_byte));
            end
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== bench/tb_serial_net_drive_control_ports.sv =====
// Top of the serial_net_drive_control_ports bench: clock, reset, register
// writes, bus stimulus, a stall watchdog; port_access_checker checks results.
// Depends on sndcp_pkg, the block and bench/port_access_checker.sv.
module tb_serial_net_drive_control_ports;

    localparam int STALL_LIMIT = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = '0;
    logic [7:0]  cfg_data = '0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    logic        acc_cmd = 1'b0;
    logic [15:0] acc_addr = '0;
    logic [7:0]  acc_wval = '0;
    logic        ser_rdy = 1'b0;
    logic [7:0]  ser_byte = '0;
    logic        net_rdy = 1'b0;
    logic [7:0]  net_byte = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [7:0]  read_value;
    logic        claimed;
    logic        ser_taken;
    logic        net_taken;
    logic        send_valid;
    logic        send_target;
    logic [7:0]  send_byte;
    logic [7:0]  motors_on;
    int          pending;
    int          fail_count;

    // stimulus-side shadows
    logic        calm = 1'b0;
    logic        iface_on = 1'b0;
    logic        comms_shadow = 1'b0;
    logic        station_armed = 1'b0;
    int          accesses = 0;
    int unsigned stalled = 0;

    serial_net_drive_control_ports i_dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_we            (cfg_we),
        .i_cfg_idx           (cfg_idx),
        .i_cfg_data          (cfg_data),
        .i_valid             (req_valid),
        .o_ready             (req_ready),
        .i_cmd               (acc_cmd),
        .i_port_address      (acc_addr),
        .i_write_value       (acc_wval),
        .i_serial_byte_ready (ser_rdy),
        .i_serial_byte       (ser_byte),
        .i_net_byte_ready    (net_rdy),
        .i_net_byte          (net_byte),
        .o_valid             (res_valid),
        .i_ready             (res_ready),
        .o_read_value        (read_value),
        .o_claimed           (claimed),
        .o_serial_byte_taken (ser_taken),
        .o_net_byte_taken    (net_taken),
        .o_send_valid        (send_valid),
        .o_send_target       (send_target),
        .o_send_byte         (send_byte),
        .o_motors_on         (motors_on)
    );

    port_access_checker i_checker (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_we            (cfg_we),
        .i_cfg_idx           (cfg_idx),
        .i_cfg_data          (cfg_data),
        .i_req_valid         (req_valid),
        .i_req_ready         (req_ready),
        .i_cmd               (acc_cmd),
        .i_port_address      (acc_addr),
        .i_write_value       (acc_wval),
        .i_serial_byte_ready (ser_rdy),
        .i_serial_byte       (ser_byte),
        .i_net_byte_ready    (net_rdy),
        .i_net_byte          (net_byte),
        .i_res_valid         (res_valid),
        .i_res_ready         (res_ready),
        .i_read_value        (read_value),
        .i_claimed           (claimed),
        .i_serial_byte_taken (ser_taken),
        .i_net_byte_taken    (net_taken),
        .i_send_valid        (send_valid),
        .i_send_target       (send_target),
        .i_send_byte         (send_byte),
        .i_motors_on         (motors_on),
        .o_pending           (pending),
        .o_fail_count        (fail_count)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        res_ready <= calm || ($urandom_range(0, 99) >= 28);
    end

    always @(posedge clk) begin
        if ((req_valid && req_ready) || (res_valid && res_ready)) stalled <= 0;
        else stalled <= stalled + 1;
        if (stalled >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic issue(input logic cmd, input logic [15:0] addr, input logic [7:0] wval,
                         input logic s_rdy, input logic [7:0] s_byte,
                         input logic n_rdy, input logic [7:0] n_byte);
        // hold the station handshake back until the closing sequence
        if (cmd == sndcp_pkg::CMD_WRITE && addr[4:3] == sndcp_pkg::PORT_LAN
                && !comms_shadow && !station_armed)
            wval[0] = 1'b1;
        if (cmd == sndcp_pkg::CMD_WRITE && addr[4:3] == sndcp_pkg::PORT_CTRL && iface_on)
            comms_shadow = wval[0];
        if (iface_on) accesses++;
        if (!calm) begin
            while ($urandom_range(0, 99) < 28) begin
                req_valid <= 1'b0;
                @(posedge clk);
            end
        end
        req_valid <= 1'b1;
        acc_cmd   <= cmd;
        acc_addr  <= addr;
        acc_wval  <= wval;
        ser_rdy   <= s_rdy;
        ser_byte  <= s_byte;
        net_rdy   <= n_rdy;
        net_byte  <= n_byte;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    function automatic logic [15:0] addr_for(input sndcp_pkg::t_port_sel sel);
        logic [15:0] a;
        a = 16'($urandom);
        a[4:3] = sel;
        return a;
    endfunction

    task automatic rd(input sndcp_pkg::t_port_sel sel);
        issue(sndcp_pkg::CMD_READ, addr_for(sel), 8'($urandom), $urandom_range(0, 3) != 0,
              8'($urandom), $urandom_range(0, 3) != 0, 8'($urandom));
    endtask

    task automatic wr(input sndcp_pkg::t_port_sel sel, input logic [7:0] v);
        issue(sndcp_pkg::CMD_WRITE, addr_for(sel), v, $urandom_range(0, 3) != 0,
              8'($urandom), $urandom_range(0, 3) != 0, 8'($urandom));
    endtask

    task automatic noise();
        repeat ($urandom_range(3, 10))
            issue(1'($urandom), 16'($urandom), 8'($urandom), 1'($urandom),
                  8'($urandom), 1'($urandom), 8'($urandom));
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic configure(input logic en, input logic [7:0] present,
                             input logic [7:0] wprot, input logic conn);
        logic [7:0] vals [4];
        vals[sndcp_pkg::CFG_IFACE_EN] = {7'd0, en};
        vals[sndcp_pkg::CFG_PRESENT]  = present;
        vals[sndcp_pkg::CFG_WPROT]    = wprot;
        vals[sndcp_pkg::CFG_SER_CONN] = {7'd0, conn};
        drain();
        for (int k = 0; k < 4; k++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= sndcp_pkg::t_cfg_idx'(k);
            cfg_data <= vals[k];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        iface_on = en;
    endtask

    task automatic serial_rx_burst();
        logic [7:0] v;
        v = 8'($urandom);
        v[4] = ($urandom_range(0, 7) != 0);
        wr(sndcp_pkg::PORT_CTRL, v);
        repeat ($urandom_range(10, 40)) rd(sndcp_pkg::PORT_LAN);
    endtask

    task automatic serial_tx_frame();
        logic [7:0] v;
        // rising data bit clears the counters, then idle low, start, data, stop
        v = 8'($urandom);
        v[0] = 1'b0;
        wr(sndcp_pkg::PORT_CTRL, v);
        v[0] = 1'b1;
        wr(sndcp_pkg::PORT_CTRL, v);
        wr(sndcp_pkg::PORT_LAN, {7'($urandom), 1'b0});
        wr(sndcp_pkg::PORT_LAN, {7'($urandom), 1'b1});
        repeat (10) wr(sndcp_pkg::PORT_LAN, 8'($urandom));
    endtask

    task automatic motor_run();
        logic [7:0] v;
        repeat ($urandom_range(1, 5)) begin
            v = 8'($urandom);
            v[1] = 1'b1;
            wr(sndcp_pkg::PORT_CTRL, v);
            v = 8'($urandom);
            v[1] = 1'b0;
            wr(sndcp_pkg::PORT_CTRL, v);
        end
        repeat ($urandom_range(5, 40)) rd(sndcp_pkg::PORT_CTRL);
    endtask

    task automatic station_handoff();
        logic [7:0] v;
        station_armed = 1'b1;
        v = 8'($urandom);
        v[0] = 1'b0;
        wr(sndcp_pkg::PORT_CTRL, v);
        // step through the handshake cycle so a low bit lands in the window
        repeat (12) begin
            repeat (30) rd(sndcp_pkg::PORT_LAN);
            wr(sndcp_pkg::PORT_LAN, {7'($urandom), 1'b0});
        end
        repeat (9) wr(sndcp_pkg::PORT_LAN, 8'($urandom));
    endtask

    task automatic random_phase(input int target);
        int stop;
        int pick;
        stop = accesses + target;
        while (accesses < stop) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) serial_rx_burst();
            else if (pick < 30) serial_tx_frame();
            else if (pick < 45) motor_run();
            else if (pick < 75) repeat ($urandom_range(20, 80)) rd(sndcp_pkg::PORT_LAN);
            else noise();
        end
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // interface still paged out after reset
        rd(sndcp_pkg::PORT_CTRL);
        wr(sndcp_pkg::PORT_CTRL, 8'hFF);

        configure(1'b1, 8'hFF, 8'h0F, 1'b1);
        issue(sndcp_pkg::CMD_READ, 16'h0000, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00);
        issue(sndcp_pkg::CMD_WRITE, 16'h0000, 8'hFF, 1'b1, 8'hFF, 1'b1, 8'hFF);
        issue(sndcp_pkg::CMD_READ, 16'hFFFF, 8'hFF, 1'b1, 8'hFF, 1'b1, 8'hFF);
        issue(sndcp_pkg::CMD_WRITE, 16'hFFFF, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00);
        rd(sndcp_pkg::PORT_CTRL);
        wr(sndcp_pkg::PORT_CTRL, 8'h02);
        wr(sndcp_pkg::PORT_CTRL, 8'h00);
        wr(sndcp_pkg::PORT_CTRL, 8'h02);
        wr(sndcp_pkg::PORT_CTRL, 8'h01);
        rd(sndcp_pkg::PORT_CTRL);
        rd(sndcp_pkg::PORT_CTRL);
        rd(sndcp_pkg::PORT_LAN);
        wr(sndcp_pkg::PORT_CTRL, 8'h30);
        issue(sndcp_pkg::CMD_READ, addr_for(sndcp_pkg::PORT_LAN), 8'h00, 1'b1, 8'hFF,
              1'b0, 8'h00);
        repeat (13) rd(sndcp_pkg::PORT_LAN);

        calm = 1'b1;
        configure(1'b1, 8'hFF, 8'hFF, 1'b1);
        random_phase(250);
        calm = 1'b0;

        configure(1'b1, 8'h00, 8'h00, 1'b0);
        random_phase(150);
        configure(1'b1, 8'($urandom), 8'($urandom), 1'($urandom));
        random_phase(150);
        configure(1'b1, 8'($urandom), 8'($urandom), 1'($urandom));
        random_phase(150);

        configure(1'b0, 8'($urandom), 8'($urandom), 1'($urandom));
        repeat (4) noise();

        configure(1'b1, 8'($urandom), 8'($urandom), 1'b1);
        station_handoff();
        random_phase(60);

        drain();
        repeat (4) @(posedge clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
